// ===== sv/ipq_pkg.sv =====
// Shared types, character codes and segment check for the IPv4 dotted-quad parser.
// No dependencies; imported by every module of the block.
package ipq_pkg;

    localparam logic [7:0] CHAR_ZERO = 8'h30;
    localparam logic [7:0] CHAR_NINE = 8'h39;
    localparam logic [7:0] CHAR_DOT  = 8'h2E;

    localparam logic [9:0] SEG_MAX    = 10'd255;
    localparam logic [1:0] MAX_DIGITS = 2'd3;
    localparam logic [1:0] LAST_SEG   = 2'd3;

    typedef enum logic [1:0] {
        CK_DIGIT,
        CK_DOT,
        CK_BAD
    } char_kind_t;

    typedef enum logic [2:0] {
        FLT_NONE     = 3'd0,
        FLT_BADCHAR  = 3'd1,
        FLT_EMPTY    = 3'd2,
        FLT_LONG     = 3'd3,
        FLT_LEADZERO = 3'd4,
        FLT_RANGE    = 3'd5,
        FLT_COUNT    = 3'd6
    } fault_t;

    // classified character as it travels from front to back
    typedef struct packed {
        char_kind_t kind;
        logic [3:0] digit;
        logic       last;
    } ipq_item_t;

    // fault of a segment that is being closed
    function automatic fault_t check_seg(input logic [9:0] value,
                                         input logic [1:0] digits,
                                         input logic       first_zero);
        fault_t f;
        f = FLT_NONE;
        if (digits == 2'd0)
        begin
            f = FLT_EMPTY;
        end
        else if (first_zero && digits > 2'd1)
        begin
            f = FLT_LEADZERO;
        end
        else if (value > SEG_MAX)
        begin
            f = FLT_RANGE;
        end
        return f;
    endfunction

endpackage

// ===== sv/ipv4_dotted_quad_parser_top.sv =====
// Top level of the IPv4 dotted-decimal address parser.
// Depends on ipq_pkg, ipq_front, ipq_fifo and ipq_back.
// Usage:
//   Slave stream: one ASCII character per word on s_tdata, s_tlast set on the
//   last character of the address text. A word is taken when s_tvalid and
//   s_tready are both high.
//   Master stream: one result word per text, issued for the s_tlast character:
//   m_tdata carries the 32-bit address (first segment in bits 31:24, zero when
//   invalid), m_tuser carries the valid flag and the fault code.
//   Fault codes: 0 ok, 1 bad char, 2 empty segment, 3 too long,
//   4 leading zero, 5 over 255, 6 wrong segment count. The first fault wins.
// Throughput: one character per cycle unless a final character waits on a busy result
//   slot; the segment update (multiply by ten via shifts, add) is combinational.
// Path: the last character is held in the front register, then written into the queue,
//   then popped into the result register, which raises m_tvalid.
// Stall: a stalled m_tready holds the result register; the back end keeps
//   consuming non-final characters and only blocks on the next last
//   character, after which the two-entry queue and front register fill
//   and s_tready drops.
// Reset: rst_n (async, active low) empties the queue, clears segment state, drops m_tvalid.
module ipv4_dotted_quad_parser_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    input  logic        s_tlast,   // is_final
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] address
    output logic [3:0]  m_tuser    // [0] addr_ok, [3:1] fault_kind
);
    import ipq_pkg::*;

    logic      fr_valid;
    logic      fr_ready;
    ipq_item_t fr_item;
    logic      q_valid;
    logic      q_ready;
    ipq_item_t q_item;
    logic      addr_ok;
    logic [2:0] fault_kind;

    assign m_tuser = {fault_kind, addr_ok};

    ipq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .char_code (s_tdata),
        .is_final  (s_tlast),
        .out_valid (fr_valid),
        .out_ready (fr_ready),
        .out_item  (fr_item)
    );

    ipq_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_valid (fr_valid),
        .wr_ready (fr_ready),
        .wr_item  (fr_item),
        .rd_valid (q_valid),
        .rd_ready (q_ready),
        .rd_item  (q_item)
    );

    ipq_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (q_valid),
        .in_ready   (q_ready),
        .in_item    (q_item),
        .res_valid  (m_tvalid),
        .res_ready  (m_tready),
        .addr_ok    (addr_ok),
        .address    (m_tdata),
        .fault_kind (fault_kind)
    );

endmodule

// ===== sv/ipq_front.sv =====
// Front end: accepts input words and classifies each character (digit, dot, other).
// Depends on ipq_pkg.
module ipq_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [7:0]         char_code,
    input  logic               is_final,
    output logic               out_valid,
    input  logic               out_ready,
    output ipq_pkg::ipq_item_t out_item
);
    import ipq_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    ipq_item_t item_reg;
    ipq_item_t item_next;
    logic      take;

    assign in_ready  = !valid_reg || out_ready;
    assign take      = in_valid && in_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_comb
    begin
        logic [7:0] offset;
        offset          = char_code - CHAR_ZERO;
        item_next.digit = offset[3:0];
        item_next.last  = is_final;
        if (char_code inside {[CHAR_ZERO:CHAR_NINE]})
        begin
            item_next.kind = CK_DIGIT;
        end
        else if (char_code == CHAR_DOT)
        begin
            item_next.kind = CK_DOT;
        end
        else
        begin
            item_next.kind = CK_BAD;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

endmodule

// ===== sv/ipq_fifo.sv =====
// Two-entry queue of classified characters between front and back ends.
// Depends on ipq_pkg.
module ipq_fifo (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               wr_valid,
    output logic               wr_ready,
    input  ipq_pkg::ipq_item_t wr_item,
    output logic               rd_valid,
    input  logic               rd_ready,
    output ipq_pkg::ipq_item_t rd_item
);
    import ipq_pkg::*;

    ipq_item_t  mem_reg [2];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] count_reg;
    logic [1:0] count_next;
    logic       push;
    logic       pop;

    assign wr_ready = (count_reg != 2'd2);
    assign rd_valid = (count_reg != 2'd0);
    assign rd_item  = mem_reg[rd_ptr_reg];
    assign push     = wr_valid && wr_ready;
    assign pop      = rd_valid && rd_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

endmodule

// ===== sv/ipq_back.sv =====
// Back end: segment state, fault tracking and the registered result word.
// Depends on ipq_pkg.
module ipq_back (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  ipq_pkg::ipq_item_t in_item,
    output logic               res_valid,
    input  logic               res_ready,
    output logic               addr_ok,
    output logic [31:0]        address,
    output logic [2:0]         fault_kind
);
    import ipq_pkg::*;

    logic [9:0]  seg_value_reg;
    logic [9:0]  seg_value_next;
    logic [1:0]  seg_digits_reg;
    logic [1:0]  seg_digits_next;
    logic [1:0]  seg_index_reg;
    logic [1:0]  seg_index_next;
    logic [23:0] octets_reg;
    logic [23:0] octets_next;
    logic        first_zero_reg;
    logic        first_zero_next;
    fault_t      fault_reg;
    fault_t      fault_next;

    logic        res_valid_reg;
    logic        res_valid_next;
    logic        addr_ok_reg;
    logic [31:0] address_reg;
    fault_t      fault_kind_reg;

    fault_t      res_fault;
    logic [31:0] res_addr;
    logic        pop;
    logic        slot_free;

    // non-final characters never need the result slot
    assign slot_free  = !res_valid_reg || res_ready;
    assign in_ready   = !in_item.last || slot_free;
    assign pop        = in_valid && in_ready;

    assign res_valid  = res_valid_reg;
    assign addr_ok    = addr_ok_reg;
    assign address    = address_reg;
    assign fault_kind = fault_kind_reg;

    // character step
    always_comb
    begin
        fault_t     f;
        logic [9:0] times_ten;
        times_ten       = {seg_value_reg[6:0], 3'b000} + {seg_value_reg[8:0], 1'b0};
        f               = FLT_NONE;
        seg_value_next  = seg_value_reg;
        seg_digits_next = seg_digits_reg;
        seg_index_next  = seg_index_reg;
        octets_next     = octets_reg;
        first_zero_next = first_zero_reg;
        fault_next      = fault_reg;
        if (fault_reg == FLT_NONE)
        begin
            case (in_item.kind)
                CK_DIGIT:
                begin
                    if (seg_digits_reg == MAX_DIGITS)
                    begin
                        fault_next = FLT_LONG;
                    end
                    else
                    begin
                        if (seg_digits_reg == 2'd0 && in_item.digit == 4'd0)
                        begin
                            first_zero_next = 1'b1;
                        end
                        seg_value_next  = times_ten + {6'd0, in_item.digit};
                        seg_digits_next = seg_digits_reg + 2'd1;
                    end
                end
                CK_DOT:
                begin
                    f = check_seg(seg_value_reg, seg_digits_reg, first_zero_reg);
                    if (f == FLT_NONE && seg_index_reg == LAST_SEG)
                    begin
                        f = FLT_COUNT;
                    end
                    if (f != FLT_NONE)
                    begin
                        fault_next = f;
                    end
                    else
                    begin
                        octets_next     = {octets_reg[15:0], seg_value_reg[7:0]};
                        seg_index_next  = seg_index_reg + 2'd1;
                        seg_value_next  = 10'd0;
                        seg_digits_next = 2'd0;
                        first_zero_next = 1'b0;
                    end
                end
                default:
                begin
                    fault_next = FLT_BADCHAR;
                end
            endcase
        end
    end

    // result of a final character, from the state after its step
    always_comb
    begin
        res_fault = fault_next;
        if (res_fault == FLT_NONE)
        begin
            res_fault = check_seg(seg_value_next, seg_digits_next, first_zero_next);
            if (res_fault == FLT_NONE && seg_index_next != LAST_SEG)
            begin
                res_fault = FLT_COUNT;
            end
        end
        res_addr = (res_fault == FLT_NONE) ? {octets_next, seg_value_next[7:0]} : 32'd0;
    end

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (pop && in_item.last)
        begin
            res_valid_next = 1'b1;
        end
        else if (res_ready)
        begin
            res_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seg_value_reg  <= 10'd0;
            seg_digits_reg <= 2'd0;
            seg_index_reg  <= 2'd0;
            octets_reg     <= 24'd0;
            first_zero_reg <= 1'b0;
            fault_reg      <= FLT_NONE;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
            if (pop)
            begin
                if (in_item.last)
                begin
                    seg_value_reg  <= 10'd0;
                    seg_digits_reg <= 2'd0;
                    seg_index_reg  <= 2'd0;
                    octets_reg     <= 24'd0;
                    first_zero_reg <= 1'b0;
                    fault_reg      <= FLT_NONE;
                end
                else
                begin
                    seg_value_reg  <= seg_value_next;
                    seg_digits_reg <= seg_digits_next;
                    seg_index_reg  <= seg_index_next;
                    octets_reg     <= octets_next;
                    first_zero_reg <= first_zero_next;
                    fault_reg      <= fault_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && in_item.last)
        begin
            addr_ok_reg    <= (res_fault == FLT_NONE);
            address_reg    <= res_addr;
            fault_kind_reg <= res_fault;
        end
    end

endmodule

// ===== sim/ipq_checker.sv =====
// Checker for the IPv4 dotted-quad parser: watches both stream channels, predicts each result.
// Depends on ipq_pkg for fault codes and character constants.
module ipq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [31:0] m_tdata,
    input  logic [3:0]  m_tuser,
    output int          fail_count,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import ipq_pkg::*;

    localparam int PRINT_CAP = 50;

    typedef struct {
        logic        ok;
        logic [31:0] addr;
        fault_t      fault;
    } addr_result_t;

    addr_result_t addr_due[$];
    addr_result_t oldest;

    // predictor state
    logic [9:0]  seg_val;
    logic [1:0]  seg_cnt;
    logic [1:0]  seg_idx;
    logic [23:0] octets;
    logic        lead_zero;
    fault_t      held_fault;

    initial
    begin
        fail_count = 0;
        pending    = 0;
    end

    function automatic fault_t segment_fault();
        if (seg_cnt == 2'd0)
        begin
            return FLT_EMPTY;
        end
        if (lead_zero && seg_cnt > 2'd1)
        begin
            return FLT_LEADZERO;
        end
        if (seg_val > SEG_MAX)
        begin
            return FLT_RANGE;
        end
        return FLT_NONE;
    endfunction

    task automatic clear_parse();
        seg_val    = '0;
        seg_cnt    = '0;
        seg_idx    = '0;
        octets     = '0;
        lead_zero  = 1'b0;
        held_fault = FLT_NONE;
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        if (fail_count < PRINT_CAP)
        begin
            $display("%0t mismatch %s: got %0h, want %0h", $realtime, what, got, want);
        end
        fail_count++;
    endtask

    // one accepted character; a final one queues the expected result
    task automatic parse_char(input logic [7:0] c, input logic fin);
        fault_t       f;
        addr_result_t r;
        if (held_fault == FLT_NONE)
        begin
            if (c >= CHAR_ZERO && c <= CHAR_NINE)
            begin
                if (seg_cnt >= MAX_DIGITS)
                begin
                    held_fault = FLT_LONG;
                end
                else
                begin
                    if (seg_cnt == 2'd0 && c == CHAR_ZERO)
                    begin
                        lead_zero = 1'b1;
                    end
                    seg_val = seg_val * 10'd10 + 10'(c - CHAR_ZERO);
                    seg_cnt = seg_cnt + 2'd1;
                end
            end
            else if (c == CHAR_DOT)
            begin
                f = segment_fault();
                if (f == FLT_NONE && seg_idx == LAST_SEG)
                begin
                    f = FLT_COUNT;
                end
                if (f != FLT_NONE)
                begin
                    held_fault = f;
                end
                else
                begin
                    octets    = {octets[15:0], seg_val[7:0]};
                    seg_idx   = seg_idx + 2'd1;
                    seg_val   = '0;
                    seg_cnt   = '0;
                    lead_zero = 1'b0;
                end
            end
            else
            begin
                held_fault = FLT_BADCHAR;
            end
        end
        if (fin)
        begin
            f = held_fault;
            if (f == FLT_NONE)
            begin
                f = segment_fault();
                if (f == FLT_NONE && seg_idx != LAST_SEG)
                begin
                    f = FLT_COUNT;
                end
            end
            r.ok    = (f == FLT_NONE);
            r.addr  = r.ok ? {octets, seg_val[7:0]} : 32'd0;
            r.fault = f;
            addr_due.push_back(r);
            clear_parse();
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clear_parse();
            addr_due.delete();
            pending <= 0;
        end
        else
        begin
            if (s_tvalid && s_tready)
            begin
                parse_char(s_tdata, s_tlast);
            end
            if (m_tvalid && m_tready)
            begin
                if (addr_due.size() == 0)
                begin
                    report_mismatch("result with none expected", m_tdata, 32'd0);
                end
                else
                begin
                    oldest = addr_due.pop_front();
                    if (m_tuser[0] !== oldest.ok)
                    begin
                        report_mismatch("addr_ok", 32'(m_tuser[0]), 32'(oldest.ok));
                    end
                    if (m_tdata !== oldest.addr)
                    begin
                        report_mismatch("address", m_tdata, oldest.addr);
                    end
                    if (m_tuser[3:1] !== oldest.fault)
                    begin
                        report_mismatch("fault_kind", 32'(m_tuser[3:1]), 32'(oldest.fault));
                    end
                end
            end
            pending <= addr_due.size();
        end
    end

endmodule

// ===== sim/tb.sv =====
// Testbench top for the IPv4 dotted-quad parser: clock, reset, text stimulus, verdict.
// Depends on ipq_pkg, ipv4_dotted_quad_parser_top and ipq_checker.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ipq_pkg::*;

    localparam int TOTAL_CHARS    = 1750;
    localparam int QUIET_AFTER    = 1500;  // no idling on either side past this point
    localparam int HOLD_AT        = 500;   // characters sent before the long receiver stall
    localparam int HOLD_CYCLES    = 300;
    localparam int WATCHDOG_LIMIT = 4000;  // well above the long stall
    localparam int DRAIN_CYCLES   = 8;

    logic        clk;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata  = 8'd0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;
    logic [3:0]  m_tuser;

    int fail_count;
    int pending;

    // stimulus bookkeeping
    logic [7:0] text_buf[$];
    int         sent      = 0;
    int         gap_pct   = 0;
    logic       quiet     = 1'b0;
    logic       hold_req  = 1'b0;
    logic       hold_done = 1'b0;
    int         idle_cycles = 0;

    ipv4_dotted_quad_parser_top u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // predicts and compares every result word, reports the failure count
    ipq_checker u_chk (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog: any stretch with no word moving on either channel that
    // outlasts the limit means the block is hung.
    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
        begin
            idle_cycles = 0;
        end
        else
        begin
            idle_cycles++;
        end
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // Receiver: random ready bursts and stalls; one long hold-off while the
    // sender keeps offering, so the queue fills and s_tready drops.
    initial
    begin
        @(posedge rst_n);
        forever
        begin
            if (hold_req && !hold_done)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            else if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 16)) @(posedge clk);
            end
        end
    end

    // Offer one character word and wait for its handshake. A gap, when
    // taken, drops s_tvalid in the step of the previous accept.
    task automatic put_word(input logic [7:0] c, input logic fin);
        if (!quiet && $urandom_range(1, 100) <= gap_pct)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= fin;
        @(posedge clk);
        while (!s_tready)
        begin
            @(posedge clk);
        end
        sent++;
        if (sent == HOLD_AT)
        begin
            hold_req = 1'b1;
        end
        if (sent >= QUIET_AFTER)
        begin
            quiet = 1'b1;
        end
    endtask

    // Send the text buffer, flagging its last character, then clear it.
    task automatic send_text();
        gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(5, 40);
        foreach (text_buf[i])
        begin
            put_word(text_buf[i], i == text_buf.size() - 1);
        end
        text_buf.delete();
    endtask

    task automatic send_string(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_buf.push_back(s[i]);
        end
        send_text();
    endtask

    task automatic append_octet(input int unsigned v);
        if (v >= 100)
        begin
            text_buf.push_back(CHAR_ZERO + 8'(v / 100));
        end
        if (v >= 10)
        begin
            text_buf.push_back(CHAR_ZERO + 8'((v / 10) % 10));
        end
        text_buf.push_back(CHAR_ZERO + 8'(v % 10));
    endtask

    // One random text: mostly well-formed quads (some damaged in one spot),
    // then digit/dot sequences of any shape, then raw byte noise.
    task automatic build_random_text();
        int unsigned v;
        int          kind;
        int          p;
        kind = $urandom_range(0, 9);
        if (kind <= 5)
        begin
            for (int s = 0; s < 4; s++)
            begin
                if (s > 0)
                begin
                    text_buf.push_back(CHAR_DOT);
                end
                case ($urandom_range(0, 5))
                    0: v = 0;
                    1: v = 255;
                    default: v = $urandom_range(0, 255);
                endcase
                append_octet(v);
            end
            if ($urandom_range(0, 2) == 0)
            begin
                p = $urandom_range(0, text_buf.size() - 1);
                case ($urandom_range(0, 3))
                    0: text_buf[p] = 8'($urandom_range(0, 255));
                    1: text_buf.insert(p, CHAR_ZERO + 8'($urandom_range(0, 9)));
                    2: text_buf.insert(p, CHAR_DOT);
                    default: text_buf.delete(p);
                endcase
            end
        end
        else if (kind <= 8)
        begin
            // segment lengths 0..4 and counts 1..5, digits unconstrained
            p = $urandom_range(1, 5);
            for (int s = 0; s < p; s++)
            begin
                if (s > 0)
                begin
                    text_buf.push_back(CHAR_DOT);
                end
                repeat ($urandom_range(0, 4))
                begin
                    text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
                end
            end
        end
        else
        begin
            repeat ($urandom_range(1, 6))
            begin
                case ($urandom_range(0, 3))
                    0: text_buf.push_back(CHAR_DOT);
                    1: text_buf.push_back(":");
                    default: text_buf.push_back(8'($urandom_range(0, 255)));
                endcase
            end
        end
        if (text_buf.size() == 0)
        begin
            text_buf.push_back(CHAR_ZERO + 8'($urandom_range(0, 9)));
        end
    endtask

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: the all-255 address and each fault kind
        send_string("255.255.255.255");
        send_string("0.0.0.0.");     // fifth segment
        send_string(":");            // colon is a bad character
        send_string("1234");         // fourth digit is too long
        send_string("01.");          // leading zero
        send_string("256");          // over 255
        send_string(".");            // empty segment
        send_string("7");            // too few segments
        text_buf.push_back(8'h00);   // NUL
        send_text();
        text_buf.push_back(8'hFF);
        send_text();

        while (sent < TOTAL_CHARS)
        begin
            build_random_text();
            send_text();
        end
        s_tvalid <= 1'b0;
        s_tlast  <= 1'b0;

        // drain: let the last expectation register, then wait it out
        @(posedge clk);
        while (pending != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && pending == 0)
        begin
            $display("status: pass");
        end
        else
        begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
